// ----- hdl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

   // store depth default and field widths
   localparam int STORE_DEPTH_DEF = 256;
   localparam int POS_W           = 9;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLKH   = 3'd4;

   // register reset values
   localparam logic [15:0] TEMPO_RST  = 16'd100;
   localparam logic [8:0]  LENGTH_RST = 9'd1;
   localparam logic [31:0] CLKH_RST   = 32'd1680000;

   // frequencies at or below this are silent
   localparam logic [11:0] FREQ_MIN = 12'h012;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  entry_index;
      logic [15:0] entry_value;
   } req_type;

   typedef struct packed {
      logic        tone_enable;
      logic [31:0] prescaler_value;
      logic        playing;
      logic [7:0]  note_position;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic note;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_read;
      logic tone_ok;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ----- hdl/mts_divider.sv -----
// ----------------------------------------------------------------------------
// mts_divider
// Restoring divider, 32-bit dividend by 12-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mts_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [11:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [12:0] shifted;
   logic [13:0] diff;
   logic        fits;

   // one quotient bit per step
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      fits    = ~diff[13];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], fits};
         rem_in = fits ? diff[11:0] : shifted[11:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- hdl/mts_datapath.sv -----
// ----------------------------------------------------------------------------
// mts_datapath
// Registers, note store, playback state, prescaler divider, result register.
// ----------------------------------------------------------------------------
module mts_datapath #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mts_pkg::req_type                 req_data,
   output mts_pkg::rsp_type                 rsp_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             csr_write_en,
   input  logic [mts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  mts_pkg::cmd_type                 cmd,
   output mts_pkg::sts_type                 sts
);
   import mts_pkg::*;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [16:0] DEPTH_L = 17'(STORE_DEPTH);

   // index modulo store depth, eight compare-subtract steps
   function automatic logic [23:0] mod_depth(input logic [7:0] idx);
      logic [23:0] r;
      logic [23:0] sub;
      r = {16'b0, idx};
      for (int k = 7; k >= 0; k--) begin
         sub = 24'(STORE_DEPTH) << k;
         if (r >= sub) r = r - sub;
      end
      return r;
   endfunction

   // configuration registers
   logic [15:0] tempo_ff;
   logic [8:0]  len_ff;
   logic        rep_ff;
   logic        mute_ff;
   logic [31:0] clkh_ff;

   // playback state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [19:0]      ticks_ff, ticks_in;
   logic             active_ff, active_in;
   logic [31:0]      presc_ff, presc_in;
   logic             running_ff, running_in;

   // captured item
   logic [1:0]  op_ff;
   logic [7:0]  idx_ff;
   logic [15:0] val_ff;

   // note store
   logic [15:0] note_mem_ff [STORE_DEPTH];
   logic [15:0] rd_data_ff;

   // result register
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;

   logic [16:0]       eff_len;
   logic [16:0]       pos_inc;
   logic [16:0]       pos_ext;
   logic [19:0]       ticks_dec;
   logic              start_ok;
   logic              advance;
   logic              past_end;
   logic [11:0]       freq;
   logic [3:0]        dur;
   logic [19:0]       note_ticks;
   logic              tone_ok;
   logic [23:0]       wr_mod;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              div_done;
   logic [31:0]       div_quo;

   // derived values
   always_comb begin
      eff_len    = ({8'b0, len_ff} > DEPTH_L) ? DEPTH_L : {8'b0, len_ff};
      pos_ext    = {8'b0, pos_ff};
      pos_inc    = pos_ext + 17'd1;
      ticks_dec  = (ticks_ff != '0) ? ticks_ff - 20'd1 : '0;
      start_ok   = (tempo_ff != '0) && (len_ff != '0);
      advance    = active_ff && (ticks_dec == '0);
      past_end   = pos_inc >= eff_len;
      freq       = rd_data_ff[15:4];
      dur        = rd_data_ff[3:0];
      note_ticks = 20'(tempo_ff * dur);
      tone_ok    = (freq > FREQ_MIN) && !mute_ff;
      wr_mod     = mod_depth(idx_ff);
      wr_addr    = wr_mod[ADDR_W-1:0];
      rd_addr    = pos_ext[ADDR_W-1:0];
   end

   // status to controller
   always_comb begin
      sts.need_read = 1'b0;
      case (op_ff)
         OP_START: sts.need_read = start_ok;
         OP_TICK:  sts.need_read = advance && (!past_end || rep_ff);
         default:  sts.need_read = 1'b0;
      endcase
      sts.tone_ok  = tone_ok;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // playback state update
   always_comb begin
      pos_in     = pos_ff;
      ticks_in   = ticks_ff;
      active_in  = active_ff;
      presc_in   = presc_ff;
      running_in = running_ff;
      if (csr_write_en && (csr_index == CSR_MUTE) && csr_wdata[0]) begin
         running_in = 1'b0;
         presc_in   = '0;
      end
      if (cmd.exec) begin
         case (op_ff)
            OP_START: begin
               if (start_ok) begin
                  active_in = 1'b1;
                  pos_in    = '0;
               end
            end
            OP_STOP: begin
               active_in  = 1'b0;
               pos_in     = '0;
               ticks_in   = '0;
               running_in = 1'b0;
               presc_in   = '0;
            end
            OP_TICK: begin
               if (active_ff) begin
                  ticks_in = ticks_dec;
                  if (advance) begin
                     if (!past_end) begin
                        pos_in = pos_inc[POS_W-1:0];
                     end else if (rep_ff) begin
                        pos_in = '0;
                     end else begin
                        active_in  = 1'b0;
                        pos_in     = '0;
                        ticks_in   = '0;
                        running_in = 1'b0;
                        presc_in   = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      // note start: duration and silence decision
      if (cmd.note) begin
         ticks_in = (note_ticks == '0) ? 20'd1 : note_ticks;
         if (!tone_ok) begin
            running_in = 1'b0;
            presc_in   = '0;
         end
      end
      if (div_done) begin
         running_in = 1'b1;
         presc_in   = div_quo;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff     <= TEMPO_RST;
         len_ff       <= LENGTH_RST;
         rep_ff       <= 1'b0;
         mute_ff      <= 1'b0;
         clkh_ff      <= CLKH_RST;
         pos_ff       <= '0;
         ticks_ff     <= '0;
         active_ff    <= 1'b0;
         presc_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TEMPO:  tempo_ff <= csr_wdata[15:0];
               CSR_LENGTH: len_ff   <= csr_wdata[8:0];
               CSR_REPEAT: rep_ff   <= csr_wdata[0];
               CSR_MUTE:   mute_ff  <= csr_wdata[0];
               CSR_CLKH:   clkh_ff  <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff     <= pos_in;
         ticks_ff   <= ticks_in;
         active_ff  <= active_in;
         presc_ff   <= presc_in;
         running_ff <= running_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item capture and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_data.operation;
         idx_ff <= req_data.entry_index;
         val_ff <= req_data.entry_value;
      end
      if (cmd.load_out) begin
         rsp_data_ff.tone_enable     <= running_ff;
         rsp_data_ff.prescaler_value <= presc_ff;
         rsp_data_ff.playing         <= active_ff;
         rsp_data_ff.note_position   <= pos_ff[7:0];
      end
   end

   // note store, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && (op_ff == OP_WRITE)) begin
         note_mem_ff[wr_addr] <= val_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= note_mem_ff[rd_addr];
      end
   end

   // prescaler = clock_hundredths / frequency
   mts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.note && tone_ok),
      .dividend (clkh_ff),
      .divisor  (freq),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_data  = rsp_data_ff;
   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- hdl/mts_ctrl.sv -----
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller state machine: sequences capture, execute, store read, note
// start, division and result load.
// ----------------------------------------------------------------------------
module mts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mts_pkg::sts_type sts,
   output mts_pkg::cmd_type cmd
);
   import mts_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_READ = 6'b000100,
      ST_NOTE = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = sts.need_read ? ST_READ : ST_DONE;
         ST_READ: state_in = ST_NOTE;
         ST_NOTE: state_in = sts.tone_ok ? ST_DIV : ST_DONE;
         ST_DIV:  if (sts.div_done) state_in = ST_DONE;
         ST_DONE: if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.read     = (state_ff == ST_READ);
      cmd.note     = (state_ff == ST_NOTE);
      cmd.load_out = (state_ff == ST_DONE) && sts.out_free;
   end
endmodule

// ----- hdl/melody_tone_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core
// Plays a melody from a note store; one result beat per request beat.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    mts_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    mts_pkg::rsp_type
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// A store write, stop, ignored start, or a tick that starts no note passes
// through capture, execute and result load. A beat that starts a note adds
// the store read and note setup; a sounding tone adds the 32-step restoring
// divider and the wait to see it finish. One beat is in work at a time.
// The result register lets the next request beat in while a result waits;
// the last cycle of a beat stalls while that register is still full.
// Synchronous reset; no clearing pass, the note store is not initialized.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core #(
   parameter int STORE_DEPTH = mts_pkg::STORE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mts_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mts_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [mts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and arithmetic
   mts_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts)
   );
endmodule
